/* hdl/lin_slave_frame_handler_assert.svh */
// Assertion macros for the LIN slave frame handler.
// Used by the top level; needs clk and arst_n in the including scope.
`ifndef LIN_SLAVE_FRAME_HANDLER_ASSERT_SVH
`define LIN_SLAVE_FRAME_HANDLER_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define LSFH_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define LSFH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/lsfh_pkg.sv */
// Shared types, codes and helper functions of the LIN slave frame handler.
// No dependencies; imported by every module of the block.
package lsfh_pkg;

	// Input operation codes
	localparam logic [1:0] OP_BREAK = 2'd0;
	localparam logic [1:0] OP_LINE  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;
	localparam logic [1:0] OP_READ  = 2'd3;

	// Command kinds passed from front to back
	typedef logic [2:0] cmd_kind_t;
	localparam cmd_kind_t K_BREAK  = 3'd0;
	localparam cmd_kind_t K_LINE   = 3'd1;
	localparam cmd_kind_t K_WRITE  = 3'd2;
	localparam cmd_kind_t K_READ   = 3'd3;
	localparam cmd_kind_t K_IGNORE = 3'd4;

	// Result status codes
	localparam logic [3:0] ST_PROGRESS   = 4'd0;
	localparam logic [3:0] ST_IGNORED    = 4'd1;
	localparam logic [3:0] ST_BAD_SYNC   = 4'd2;
	localparam logic [3:0] ST_BAD_PARITY = 4'd3;
	localparam logic [3:0] ST_NO_MATCH   = 4'd4;
	localparam logic [3:0] ST_RX_OK      = 4'd5;
	localparam logic [3:0] ST_CSUM_ERR   = 4'd6;
	localparam logic [3:0] ST_TX         = 4'd7;
	localparam logic [3:0] ST_HOST       = 4'd8;

	// Frame phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_SYNC = 2'd1;
	localparam logic [1:0] PH_PID  = 2'd2;
	localparam logic [1:0] PH_DATA = 2'd3;

	// Configuration register indexes
	localparam logic [2:0] REG_S0_PID = 3'd0;
	localparam logic [2:0] REG_S0_PUB = 3'd1;
	localparam logic [2:0] REG_S0_LEN = 3'd2;
	localparam logic [2:0] REG_S1_PID = 3'd3;
	localparam logic [2:0] REG_S1_PUB = 3'd4;
	localparam logic [2:0] REG_S1_LEN = 3'd5;

	localparam int         CFG_SLOTS     = 2;
	localparam logic [3:0] LEN_RESET     = 4'd8;
	localparam logic [7:0] SYNC_BYTE     = 8'h55;
	localparam logic [7:0] ID_BITS       = 8'h3F;

	// Command queue geometry
	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	typedef struct packed {
		logic [7:0] pid;
		logic       pub;
		logic [3:0] len;
	} slot_cfg_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] byte_value;
		logic       slot;
		logic [2:0] byte_index;
	} cmd_t;

	typedef struct packed {
		logic [3:0] status;
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic [7:0] read_data;
		logic       last;
	} result_t;

	// Eight-bit sum with end-around carry
	function automatic logic [7:0] add_carry(input logic [7:0] a, input logic [7:0] b);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[7:0] + {7'd0, s[8]};
	endfunction

	// Protected identifier from its low six bits (P0 in bit 6, P1 in bit 7)
	function automatic logic [7:0] make_pid(input logic [7:0] id);
		logic p0;
		logic p1;
		p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
		p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
		return {p1, p0, id[5:0]};
	endfunction

endpackage

/* hdl/lsfh_front.sv */
// Front end: accepts input words, classifies them into commands and queues them.
// Depends on lsfh_pkg.
module lsfh_front #(
	parameter int NUM_SLOTS      = 2,
	parameter int MAX_DATA_BYTES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [15:0]       s_tdata,   // byte_value[7:0], slot[8], byte_index[11:9]
	input  logic [1:0]        s_tuser,   // operation[1:0]
	output logic              cmd_valid,
	output lsfh_pkg::cmd_t    cmd,
	input  logic              cmd_pop
);
	import lsfh_pkg::*;

	cmd_t              q_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	cmd_t              cls;
	logic              out_of_range;
	logic              push;

	// Classify the incoming word
	always_comb begin
		cls.byte_value = s_tdata[7:0];
		cls.slot       = s_tdata[8];
		cls.byte_index = s_tdata[11:9];
		out_of_range   = (int'(s_tdata[8]) >= NUM_SLOTS) ||
		                 (int'(s_tdata[11:9]) >= MAX_DATA_BYTES);
		unique case (s_tuser)
			OP_BREAK: cls.kind = K_BREAK;
			OP_LINE:  cls.kind = K_LINE;
			OP_WRITE: cls.kind = out_of_range ? K_IGNORE : K_WRITE;
			OP_READ:  cls.kind = out_of_range ? K_IGNORE : K_READ;
			default:  cls.kind = K_IGNORE;
		endcase
	end

	assign s_tready  = (count_q != QCNT_W'(QDEPTH));
	assign push      = s_tvalid && s_tready;
	assign cmd_valid = (count_q != '0);
	assign cmd       = q_mem_q[rd_ptr_q];

	// Hold queued commands
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wr_ptr_q] <= cls;
		end
	end

	// Advance queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (cmd_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !cmd_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && cmd_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

/* hdl/lsfh_back.sv */
// Back end: frame state machine, data store, publish walk and output register.
// Depends on lsfh_pkg; fed by lsfh_front.
module lsfh_back #(
	parameter int NUM_SLOTS      = 2,
	parameter int MAX_DATA_BYTES = 8
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  lsfh_pkg::slot_cfg_t [lsfh_pkg::CFG_SLOTS-1:0] cfg,
	input  logic                                         cmd_valid,
	input  lsfh_pkg::cmd_t                               cmd,
	output logic                                         cmd_pop,
	output logic                                         res_valid,
	output lsfh_pkg::result_t                            res,
	input  logic                                         res_ready
);
	import lsfh_pkg::*;

	localparam int IDX_W  = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;
	localparam int CNT_W  = $clog2(MAX_DATA_BYTES + 1);
	localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	localparam logic BS_IDLE = 1'b0;
	localparam logic BS_PUB  = 1'b1;

	logic              state_q, state_d;
	logic [1:0]        phase_q, phase_d;
	logic [SLOT_W-1:0] matched_q, matched_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [7:0]        sum_q, sum_d;
	logic [7:0]        slot_data_q [NUM_SLOTS][MAX_DATA_BYTES];
	logic [7:0]        rx_buf_q [MAX_DATA_BYTES];
	logic              out_valid_q;
	result_t           out_q;

	logic              out_free;
	logic              emit;
	result_t           nres;
	logic              rx_we;
	logic              host_we;
	logic              commit;
	logic              found;
	logic [SLOT_W-1:0] match_idx;
	logic              parity_ok;
	logic [CNT_W-1:0]  n_cur;
	logic [SLOT_W-1:0] rd_slot;
	logic [IDX_W-1:0]  rd_idx;
	logic [7:0]        rd_byte;

	// Clamp a configured length into 1 .. MAX_DATA_BYTES
	function automatic logic [CNT_W-1:0] clamp_len(input logic [3:0] l);
		if (l == 4'd0) begin
			return CNT_W'(1);
		end else if (l > 4'(MAX_DATA_BYTES)) begin
			return CNT_W'(MAX_DATA_BYTES);
		end
		return l[CNT_W-1:0];
	endfunction

	// Match the line byte against the slots; the last matching slot wins
	always_comb begin
		found     = 1'b0;
		match_idx = '0;
		for (int i = 0; i < NUM_SLOTS; i++) begin
			if (cfg[i].pid == cmd.byte_value) begin
				found     = 1'b1;
				match_idx = SLOT_W'(i);
			end
		end
	end

	assign parity_ok = (make_pid(cmd.byte_value & ID_BITS) == cmd.byte_value);
	assign n_cur     = clamp_len(cfg[matched_q].len);
	assign out_free  = !out_valid_q || res_ready;
	assign cmd_pop   = cmd_valid && (state_q == BS_IDLE) && out_free;

	// Single read port into the data store, shared by host reads and the walk
	assign rd_slot = (state_q == BS_PUB) ? matched_q : SLOT_W'(cmd.slot);
	assign rd_idx  = (state_q == BS_PUB) ? count_q[IDX_W-1:0] : IDX_W'(cmd.byte_index);
	assign rd_byte = slot_data_q[rd_slot][rd_idx];

	// Work out the next result and state
	always_comb begin
		emit      = 1'b0;
		nres      = '0;
		nres.last = 1'b1;
		state_d   = state_q;
		phase_d   = phase_q;
		matched_d = matched_q;
		count_d   = count_q;
		sum_d     = sum_q;
		rx_we     = 1'b0;
		host_we   = 1'b0;
		commit    = 1'b0;
		if ((state_q == BS_PUB) && out_free) begin
			emit          = 1'b1;
			nres.status   = ST_TX;
			nres.tx_valid = 1'b1;
			if (count_q < n_cur) begin
				nres.tx_byte = rd_byte;
				nres.last    = 1'b0;
				sum_d        = add_carry(sum_q, rd_byte);
				count_d      = count_q + 1'b1;
			end else begin
				nres.tx_byte = ~sum_q;
				state_d      = BS_IDLE;
			end
		end else if (cmd_pop) begin
			emit = 1'b1;
			unique case (cmd.kind)
				K_BREAK: begin
					phase_d     = PH_SYNC;
					count_d     = '0;
					sum_d       = '0;
					nres.status = ST_PROGRESS;
				end
				K_LINE: begin
					unique case (phase_q)
						PH_SYNC: begin
							if (cmd.byte_value == SYNC_BYTE) begin
								phase_d     = PH_PID;
								nres.status = ST_PROGRESS;
							end else begin
								phase_d     = PH_IDLE;
								nres.status = ST_BAD_SYNC;
							end
						end
						PH_PID: begin
							phase_d = PH_IDLE;
							if (!parity_ok) begin
								nres.status = ST_BAD_PARITY;
							end else if (!found) begin
								nres.status = ST_NO_MATCH;
							end else begin
								matched_d = match_idx;
								count_d   = '0;
								sum_d     = cmd.byte_value;
								if (cfg[match_idx].pub) begin
									state_d = BS_PUB;
									emit    = 1'b0;
								end else begin
									phase_d     = PH_DATA;
									nres.status = ST_PROGRESS;
								end
							end
						end
						PH_DATA: begin
							if (count_q < n_cur) begin
								rx_we       = 1'b1;
								sum_d       = add_carry(sum_q, cmd.byte_value);
								count_d     = count_q + 1'b1;
								nres.status = ST_PROGRESS;
							end else begin
								phase_d = PH_IDLE;
								if (~sum_q == cmd.byte_value) begin
									commit      = 1'b1;
									nres.status = ST_RX_OK;
								end else begin
									nres.status = ST_CSUM_ERR;
								end
							end
						end
						default: begin
							nres.status = ST_IGNORED;
						end
					endcase
				end
				K_WRITE: begin
					host_we     = 1'b1;
					nres.status = ST_HOST;
				end
				K_READ: begin
					nres.status    = ST_HOST;
					nres.read_data = rd_byte;
				end
				default: begin
					nres.status = ST_IGNORED;
				end
			endcase
		end
	end

	// Hold the control state and the output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BS_IDLE;
			phase_q     <= PH_IDLE;
			matched_q   <= '0;
			count_q     <= '0;
			sum_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			phase_q   <= phase_d;
			matched_q <= matched_d;
			count_q   <= count_d;
			sum_q     <= sum_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load the output register
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q <= nres;
		end
	end

	// Capture received data bytes
	always_ff @(posedge clk) begin
		if (rx_we) begin
			rx_buf_q[count_q[IDX_W-1:0]] <= cmd.byte_value;
		end
	end

	// Update the data store from host writes and committed frames
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < NUM_SLOTS; s++) begin
				for (int i = 0; i < MAX_DATA_BYTES; i++) begin
					slot_data_q[s][i] <= '0;
				end
			end
		end else if (host_we) begin
			slot_data_q[SLOT_W'(cmd.slot)][IDX_W'(cmd.byte_index)] <= cmd.byte_value;
		end else if (commit) begin
			for (int i = 0; i < MAX_DATA_BYTES; i++) begin
				if (CNT_W'(i) < n_cur) begin
					slot_data_q[matched_q][i] <= rx_buf_q[i];
				end
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

/* hdl/lin_slave_frame_handler.sv */
// LIN slave frame handler: usage notes.
// Input words (s_*) carry one event each: a break, a received line byte, or a
// host write or read of the slot data store. Result words (m_*) carry a status
// code; a publish response gives one word per data byte plus the checksum, with
// tlast on the final word of each event, otherwise every event gives one word.
// Each input word passes the command queue, then the engine loads the result
// register; publish words follow once the identifier sets BS_PUB. A command
// queue of two entries sits between the classifying front end and the frame
// engine, so the input side keeps accepting while a result waits to be taken.
// With m_tready high, throughput is one event per cycle for single-word events,
// and a publish response holds the engine, one store read per cycle.
// The slave stalls with m_tready: the engine then holds its result register and
// the queue fills, after which s_tready drops.
// Configuration: cfg_we writes cfg_data into register cfg_index;
// indexes beyond the list are dropped. Write only while the block is idle.
// Reset (arst_n low) returns the frame state to idle, empties the queue, clears
// the data store and loads the slot registers with identifier 0, receive, and
// length eight. No clearing pass is needed after reset.
// Depends on lsfh_pkg, lsfh_front, lsfh_back and the assertion macro header.
`include "lin_slave_frame_handler_assert.svh"
module lin_slave_frame_handler #(
	parameter int NUM_SLOTS      = 2,
	parameter int MAX_DATA_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // byte_value[7:0], slot[8], byte_index[11:9]
	input  logic [1:0]  s_tuser,   // operation[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // tx_byte[7:0], read_data[15:8]
	output logic [4:0]  m_tuser,   // status[3:0], tx_valid[4]
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import lsfh_pkg::*;

	slot_cfg_t [CFG_SLOTS-1:0] cfg_q;
	logic                      cmd_valid;
	cmd_t                      cmd;
	logic                      cmd_pop;
	result_t                   res;

	// Write the slot configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s < CFG_SLOTS; s++) begin
				cfg_q[s].pid <= '0;
				cfg_q[s].pub <= 1'b0;
				cfg_q[s].len <= LEN_RESET;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_S0_PID: cfg_q[0].pid <= cfg_data;
				REG_S0_PUB: cfg_q[0].pub <= cfg_data[0];
				REG_S0_LEN: cfg_q[0].len <= cfg_data[3:0];
				REG_S1_PID: cfg_q[1].pid <= cfg_data;
				REG_S1_PUB: cfg_q[1].pub <= cfg_data[0];
				REG_S1_LEN: cfg_q[1].len <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	lsfh_front #(
		.NUM_SLOTS      (NUM_SLOTS),
		.MAX_DATA_BYTES (MAX_DATA_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	lsfh_back #(
		.NUM_SLOTS      (NUM_SLOTS),
		.MAX_DATA_BYTES (MAX_DATA_BYTES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_valid (m_tvalid),
		.res       (res),
		.res_ready (m_tready)
	);

	assign m_tdata = {res.read_data, res.tx_byte};
	assign m_tuser = {res.tx_valid, res.status};
	assign m_tlast = res.last;

	// Only transmit words carry the tx flag
	`LSFH_ASSERT_SAME(a_tx_flag, m_tvalid && m_tuser[4], m_tuser[3:0] == ST_TX, "tx flag on non-tx word")
	// Only a publish response has words that are not the last of their event
	`LSFH_ASSERT_SAME(a_not_last_tx, m_tvalid && !m_tlast, m_tuser[3:0] == ST_TX, "stray non-last word")
	// An accepted word is queued for the engine in the next cycle
	`LSFH_ASSERT_NEXT(a_queued, s_tvalid && s_tready, cmd_valid, "accepted word not queued")

endmodule
